// File: hw/rtl/mhtq_pkg.sv
// Package for the min-heap timer queue: sizes, command and result codes,
// controller states and the controller/datapath command and status structs.
// No dependencies.
package mhtq_pkg;

    localparam int CAPACITY    = 16;
    localparam int ID_WIDTH    = 8;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int MAX_FIRED   = 16;
    localparam int FCNT_W      = $clog2(MAX_FIRED + 1);

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_CANCEL = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;

    localparam logic [2:0] K_ADDED     = 3'd0;
    localparam logic [2:0] K_REJECTED  = 3'd1;
    localparam logic [2:0] K_CANCELLED = 3'd2;
    localparam logic [2:0] K_NOT_FOUND = 3'd3;
    localparam logic [2:0] K_FIRED     = 3'd4;
    localparam logic [2:0] K_DONE      = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UP_RD,
        ST_UP_CMP,
        ST_CAN_RD,
        ST_CAN_CMP,
        ST_TK_RD,
        ST_TK_CHK,
        ST_DN_RD,
        ST_DN_CMP,
        ST_OUT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture the input beat
        logic up_start;   // position = occupancy, occupancy++
        logic up_read;    // read parent of position
        logic up_move;    // copy parent down, position = parent
        logic up_place;   // write new entry at position
        logic can_start;  // index = 0
        logic can_read;   // read entry at index
        logic can_step;   // mark if match, index++
        logic tk_read;    // read root
        logic tk_pop;     // occupancy--, read last entry, position = 0
        logic dn_read;    // read children of position
        logic dn_move;    // copy child up, position = child
        logic dn_place;   // write held entry at position
        logic fire_cnt;   // count a fired result
        logic out_load;   // present a result
        logic [2:0] out_kind;
        logic out_root_id; // result id from the popped root
        logic out_last;
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] command;
        logic full;
        logic up_at_root;
        logic up_stop;
        logic can_end;
        logic found;
        logic empty;
        logic root_due;
        logic root_live;
        logic fired_max;
        logic dn_leaf;
        logic dn_stop;
        logic out_busy;
    } ctl_sts_t;

endpackage

// File: hw/rtl/mhtq_datapath.sv
// Datapath of the min-heap timer queue: heap storage, walk registers and the
// output register. Depends on mhtq_pkg.
module mhtq_datapath
    import mhtq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  ctl_cmd_t            cmd,
    output ctl_sts_t            sts,
    input  logic [1:0]          command,
    input  logic [7:0]          timer_id,
    input  logic [31:0]         expire_time,
    input  logic [31:0]         now_time,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [2:0]          kind,
    output logic [7:0]          fired_id,
    output logic [4:0]          entries_used,
    output logic                last
);

    logic [31:0]         dl_mem [CAPACITY];
    logic [ID_WIDTH-1:0] ow_mem [CAPACITY];
    logic                cn_mem [CAPACITY];

    logic [1:0]          cmd_reg;
    logic [ID_WIDTH-1:0] id_reg;
    logic [31:0]         exp_reg;
    logic [31:0]         now_reg;
    logic [CNT_W-1:0]    occ_reg;
    logic [CNT_W-1:0]    pos_reg;
    logic [FCNT_W-1:0]   fcnt_reg;
    logic                found_reg;
    // Entry held during a walk (new entry or the moved last entry).
    logic [31:0]         hd_reg;
    logic [ID_WIDTH-1:0] ho_reg;
    logic                hc_reg;
    // The held entry is loaded from the last slot in the cycle after tk_pop.
    logic                hold_ld_reg;
    // Popped root owner.
    logic [ID_WIDTH-1:0] root_id_reg;
    // Read ports: A and B.
    logic [31:0]         rda_d_reg, rdb_d_reg;
    logic [ID_WIDTH-1:0] rda_o_reg, rdb_o_reg;
    logic                rda_c_reg, rdb_c_reg;
    logic [CNT_W-1:0]    child_reg;
    logic                vld_reg;
    logic [2:0]          kind_reg;
    logic [7:0]          fid_reg;
    logic [4:0]          used_reg;
    logic                last_reg;

    logic [CNT_W-1:0] parent;
    logic [CNT_W:0]   lchild_w;
    logic [CNT_W-1:0] lchild;
    logic [CNT_W-1:0] rchild;
    logic             rc_ok;
    logic             pick_r;
    logic [CNT_W-1:0] occ_m1;
    logic [IDX_W-1:0] addr_a, addr_b, waddr;
    logic             we;
    logic [31:0]      wd;
    logic [ID_WIDTH-1:0] wo;
    logic             wc;
    logic [31:0]      ch_d;
    logic [ID_WIDTH-1:0] ch_o;
    logic             ch_c;

    assign parent   = (pos_reg - 1'b1) >> 1;
    assign lchild_w = {pos_reg, 1'b1};
    assign lchild   = lchild_w[CNT_W-1:0];
    assign rchild   = lchild + 1'b1;
    assign occ_m1   = occ_reg - 1'b1;
    // Right child exists only when it lies below occupancy (child_reg holds left).
    assign rc_ok    = ({1'b0, child_reg} + 1'b1) < {1'b0, occ_reg};
    assign pick_r   = rc_ok && (rdb_d_reg < rda_d_reg);
    assign ch_d     = pick_r ? rdb_d_reg : rda_d_reg;
    assign ch_o     = pick_r ? rdb_o_reg : rda_o_reg;
    assign ch_c     = pick_r ? rdb_c_reg : rda_c_reg;

    always_comb
    begin
        addr_a = pos_reg[IDX_W-1:0];
        addr_b = pos_reg[IDX_W-1:0];
        if (cmd.up_read)
        begin
            addr_a = parent[IDX_W-1:0];
        end
        else if (cmd.tk_read)
        begin
            addr_a = '0;
        end
        else if (cmd.tk_pop)
        begin
            addr_a = occ_m1[IDX_W-1:0];
        end
        else if (cmd.dn_read)
        begin
            addr_a = lchild[IDX_W-1:0];
            addr_b = rchild[IDX_W-1:0];
        end
        we    = 1'b0;
        waddr = pos_reg[IDX_W-1:0];
        wd    = hd_reg;
        wo    = ho_reg;
        wc    = hc_reg;
        if (cmd.up_move)
        begin
            we = 1'b1;
            wd = rda_d_reg;
            wo = rda_o_reg;
            wc = rda_c_reg;
        end
        else if (cmd.up_place || cmd.dn_place)
        begin
            we = 1'b1;
        end
        else if (cmd.dn_move)
        begin
            we = 1'b1;
            wd = ch_d;
            wo = ch_o;
            wc = ch_c;
        end
        else if (cmd.can_step && rda_o_reg == id_reg)
        begin
            we = 1'b1;
            wd = rda_d_reg;
            wo = rda_o_reg;
            wc = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            dl_mem[waddr] <= wd;
            ow_mem[waddr] <= wo;
            cn_mem[waddr] <= wc;
        end
        rda_d_reg <= dl_mem[addr_a];
        rda_o_reg <= ow_mem[addr_a];
        rda_c_reg <= cn_mem[addr_a];
        rdb_d_reg <= dl_mem[addr_b];
        rdb_o_reg <= ow_mem[addr_b];
        rdb_c_reg <= cn_mem[addr_b];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg   <= '0;
            vld_reg   <= 1'b0;
            pos_reg   <= '0;
            fcnt_reg  <= '0;
            found_reg <= 1'b0;
            cmd_reg   <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                cmd_reg   <= command;
                id_reg    <= timer_id[ID_WIDTH-1:0];
                exp_reg   <= expire_time;
                now_reg   <= now_time;
                fcnt_reg  <= '0;
                found_reg <= 1'b0;
                hd_reg    <= expire_time;
                ho_reg    <= timer_id[ID_WIDTH-1:0];
                hc_reg    <= 1'b0;
            end
            if (hold_ld_reg)
            begin
                hd_reg <= rda_d_reg;
                ho_reg <= rda_o_reg;
                hc_reg <= rda_c_reg;
            end
            if (cmd.up_start)
            begin
                pos_reg <= occ_reg;
                occ_reg <= occ_reg + 1'b1;
            end
            if (cmd.up_move)
            begin
                pos_reg <= parent;
            end
            if (cmd.can_start)
            begin
                pos_reg <= '0;
            end
            if (cmd.can_step)
            begin
                pos_reg <= pos_reg + 1'b1;
                if (rda_o_reg == id_reg)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (cmd.tk_pop)
            begin
                root_id_reg <= rda_o_reg;
                occ_reg     <= occ_m1;
                pos_reg     <= '0;
            end
            if (cmd.dn_read)
            begin
                child_reg <= lchild;
            end
            if (cmd.dn_move)
            begin
                pos_reg <= pick_r ? child_reg + 1'b1 : child_reg;
            end
            if (cmd.fire_cnt)
            begin
                fcnt_reg <= fcnt_reg + 1'b1;
            end
            if (out_valid && !out_stall)
            begin
                vld_reg <= 1'b0;
            end
            if (cmd.out_load)
            begin
                vld_reg  <= 1'b1;
                kind_reg <= cmd.out_kind;
                fid_reg  <= (cmd.out_kind == K_DONE) ? 8'd0 :
                            8'(cmd.out_root_id ? root_id_reg : id_reg);
                used_reg <= 5'(occ_reg);
                last_reg <= cmd.out_last;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_ld_reg <= 1'b0;
        end
        else
        begin
            hold_ld_reg <= cmd.tk_pop;
        end
    end

    always_comb
    begin
        sts.command    = cmd_reg;
        sts.full       = occ_reg >= CNT_W'(CAPACITY);
        sts.up_at_root = pos_reg == '0;
        sts.up_stop    = rda_d_reg <= exp_reg;
        sts.can_end    = pos_reg >= occ_reg;
        sts.found      = found_reg;
        sts.empty      = occ_reg == '0;
        sts.root_due   = now_reg >= rda_d_reg;
        sts.root_live  = !rda_c_reg;
        sts.fired_max  = fcnt_reg >= FCNT_W'(MAX_FIRED);
        sts.dn_leaf    = {1'b0, lchild_w} >= {2'b0, occ_reg};
        sts.dn_stop    = !(ch_d < hd_reg);
        sts.out_busy   = vld_reg && out_stall;
    end

    assign out_valid    = vld_reg;
    assign kind         = kind_reg;
    assign fired_id     = fid_reg;
    assign entries_used = used_reg;
    assign last         = last_reg;

`ifndef SYNTHESIS
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CNT_W'(CAPACITY))
        else $error("occupancy above capacity");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg && out_stall) |-> !cmd.out_load)
        else $error("result overwritten while stalled");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.tk_pop |-> occ_reg != '0)
        else $error("pop from empty heap");
`endif

endmodule

// File: hw/rtl/mhtq_ctrl.sv
// Controller of the min-heap timer queue: sequences add, cancel and tick
// walks over the datapath. Depends on mhtq_pkg.
module mhtq_ctrl
    import mhtq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  ctl_sts_t sts,
    output ctl_cmd_t cmd
);

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;
    ctl_cmd_t pend_reg, pend_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
            pend_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            pend_reg  <= pend_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        pend_next  = pend_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                // Dispatch happens next cycle from sts.command.
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_UP_RD;
                    ret_next   = ST_IDLE;
                end
            end
            ST_UP_RD:
            begin
                // Dispatch on captured command.
                case (sts.command)
                    CMD_ADD:
                    begin
                        if (sts.full)
                        begin
                            pend_next = '0;
                            pend_next.out_kind = K_REJECTED;
                            pend_next.out_last = 1'b1;
                            ret_next   = ST_IDLE;
                            state_next = ST_OUT;
                        end
                        else
                        begin
                            cmd.up_start = 1'b1;
                            state_next   = ST_UP_CMP;
                        end
                    end
                    CMD_CANCEL:
                    begin
                        cmd.can_start = 1'b1;
                        state_next    = ST_CAN_RD;
                    end
                    CMD_TICK:
                    begin
                        state_next = ST_TK_RD;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_UP_CMP:
            begin
                // Position is current; read parent or place at root.
                if (sts.up_at_root)
                begin
                    cmd.up_place = 1'b1;
                    pend_next = '0;
                    pend_next.out_kind = K_ADDED;
                    pend_next.out_last = 1'b1;
                    ret_next   = ST_IDLE;
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.up_read = 1'b1;
                    // Parent data arrives next cycle; evaluate in ST_DN_RD slot.
                    state_next  = ST_DN_RD;
                    ret_next    = ST_UP_CMP;
                end
            end
            ST_DN_RD:
            begin
                if (ret_reg == ST_UP_CMP)
                begin
                    // Sift-up decision on parent data.
                    if (sts.up_stop)
                    begin
                        cmd.up_place = 1'b1;
                        pend_next = '0;
                        pend_next.out_kind = K_ADDED;
                        pend_next.out_last = 1'b1;
                        ret_next   = ST_IDLE;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        cmd.up_move = 1'b1;
                        state_next  = ST_UP_CMP;
                    end
                end
                else
                begin
                    // Sift-down: read children of position or stop at a leaf.
                    if (sts.dn_leaf)
                    begin
                        cmd.dn_place = 1'b1;
                        state_next   = ST_TK_RD;
                    end
                    else
                    begin
                        cmd.dn_read = 1'b1;
                        state_next  = ST_DN_CMP;
                    end
                end
            end
            ST_DN_CMP:
            begin
                if (sts.dn_stop)
                begin
                    cmd.dn_place = 1'b1;
                    state_next   = ST_TK_RD;
                end
                else
                begin
                    cmd.dn_move = 1'b1;
                    state_next  = ST_DN_RD;
                end
            end
            ST_CAN_RD:
            begin
                if (sts.can_end)
                begin
                    pend_next = '0;
                    pend_next.out_kind = sts.found ? K_CANCELLED : K_NOT_FOUND;
                    pend_next.out_last = 1'b1;
                    ret_next   = ST_IDLE;
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.can_read = 1'b1;
                    state_next   = ST_CAN_CMP;
                end
            end
            ST_CAN_CMP:
            begin
                cmd.can_step = 1'b1;
                state_next   = ST_CAN_RD;
            end
            ST_TK_RD:
            begin
                if (sts.empty || sts.fired_max)
                begin
                    pend_next = '0;
                    pend_next.out_kind = K_DONE;
                    pend_next.out_last = 1'b1;
                    ret_next   = ST_IDLE;
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.tk_read = 1'b1;
                    state_next  = ST_TK_CHK;
                end
            end
            ST_TK_CHK:
            begin
                if (!sts.root_due)
                begin
                    pend_next = '0;
                    pend_next.out_kind = K_DONE;
                    pend_next.out_last = 1'b1;
                    ret_next   = ST_IDLE;
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.tk_pop = 1'b1;
                    ret_next   = ST_TK_RD;
                    if (sts.root_live)
                    begin
                        cmd.fire_cnt = 1'b1;
                        pend_next = '0;
                        pend_next.out_kind    = K_FIRED;
                        pend_next.out_root_id = 1'b1;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_OUT;
                        pend_next  = '0;
                        pend_next.out_kind = K_DONE;
                        pend_next.out_load = 1'b1; // marks a silent pop
                    end
                end
            end
            ST_OUT:
            begin
                // After a silent pop, stay here while the held entry is loaded; else present the result.
                if (pend_reg.out_load)
                begin
                    pend_next.out_load = 1'b0;
                    state_next = ST_DN_RD;
                    ret_next   = ST_TK_RD;
                    if (sts.empty)
                    begin
                        state_next = ST_TK_RD;
                    end
                end
                else if (!sts.out_busy)
                begin
                    cmd.out_load    = 1'b1;
                    cmd.out_kind    = pend_reg.out_kind;
                    cmd.out_root_id = pend_reg.out_root_id;
                    cmd.out_last    = pend_reg.out_last;
                    if (ret_reg == ST_TK_RD)
                    begin
                        state_next = sts.empty ? ST_TK_RD : ST_DN_RD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> in_stall)
        else $error("input taken while busy");
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> state_reg == ST_IDLE)
        else $error("load outside idle");
    a_pop_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.tk_pop |=> state_reg == ST_OUT)
        else $error("pop not followed by result stage");
`endif

endmodule

// File: hw/rtl/min_heap_timer_queue.sv
// Top level of the min-heap timer queue: controller plus datapath.
// Depends on mhtq_pkg, mhtq_ctrl and mhtq_datapath.
//
// The block holds up to 16 timers in a binary min-heap kept in a small
// two-read-port register memory, and works on one command beat at a time:
// in_stall stays high from the accepted beat until the last result beat has
// been loaded into the output register. Every walk step reads the memory,
// whose reads are registered, and then compares and writes: an add climbs
// from the new slot towards the root (up to 4 levels), a cancel scans every
// held entry, and a tick pops due roots and sinks the moved last entry until
// the heap is empty, the fired limit is hit or the root is not yet due. A
// result beat that is still waiting in the output register holds the walk
// until it is taken. Cancelled entries are dropped silently when popped; a
// full heap rejects an add. Heap storage has no reset; only entries below the
// occupancy are used.
module min_heap_timer_queue
    import mhtq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [7:0]  timer_id,
    input  logic [31:0] expire_time,
    input  logic [31:0] now_time,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  kind,
    output logic [7:0]  fired_id,
    output logic [4:0]  entries_used,
    output logic        last
);

    ctl_cmd_t cmd;
    ctl_sts_t sts;

    mhtq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    mhtq_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .command      (command),
        .timer_id     (timer_id),
        .expire_time  (expire_time),
        .now_time     (now_time),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .fired_id     (fired_id),
        .entries_used (entries_used),
        .last         (last)
    );

endmodule

// File: verif/min_heap_timer_queue_chk.sv
// Checker for the min-heap timer queue: watches both channels, keeps its own
// copy of the heap to predict every result beat, and compares field by field.
// Depends on mhtq_pkg.
`timescale 1ns / 100ps

module min_heap_timer_queue_chk
    import mhtq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  command,
    input  logic [7:0]  timer_id,
    input  logic [31:0] expire_time,
    input  logic [31:0] now_time,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [2:0]  kind,
    input  logic [7:0]  fired_id,
    input  logic [4:0]  entries_used,
    input  logic        last,
    output int          fail_count,
    output int          waiting_results,
    output int          checked_results
);

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] id;
        logic [4:0] used;
        logic       last;
    } timer_result_t;

    timer_result_t result_q[$];

    logic [31:0] heap_deadline [CAPACITY];
    logic [7:0]  heap_owner    [CAPACITY];
    logic        heap_dead     [CAPACITY];
    int          heap_count;

    function automatic timer_result_t make_result(logic [2:0] k, logic [7:0] id,
                                                  logic l);
        timer_result_t r;
        r.kind = k;
        r.id   = id;
        r.used = heap_count[4:0];
        r.last = l;
        return r;
    endfunction

    task automatic swap_slots(int a, int b);
        logic [31:0] d;
        logic [7:0]  o;
        logic        c;
        d = heap_deadline[a]; heap_deadline[a] = heap_deadline[b]; heap_deadline[b] = d;
        o = heap_owner[a];    heap_owner[a]    = heap_owner[b];    heap_owner[b]    = o;
        c = heap_dead[a];     heap_dead[a]     = heap_dead[b];     heap_dead[b]     = c;
    endtask

    // Sift down: a child moves up only when strictly earlier, and the right
    // child wins only when strictly earlier than the left one.
    task automatic settle_root();
        int pos;
        int child;
        pos = 0;
        while (2 * pos + 1 < heap_count)
        begin
            child = 2 * pos + 1;
            if (child + 1 < heap_count && heap_deadline[child + 1] < heap_deadline[child])
                child++;
            if (heap_deadline[child] < heap_deadline[pos])
            begin
                swap_slots(pos, child);
                pos = child;
            end
            else
                break;
        end
    endtask

    task automatic predict_timer_op(logic [1:0] c, logic [7:0] id_in,
                                    logic [31:0] due, logic [31:0] now);
        logic [7:0] id;
        int         pos;
        int         fired;
        logic       hit;
        logic [7:0] owner;
        logic       live;
        id = id_in & 8'((64'd1 << ID_WIDTH) - 1);
        if (c == CMD_ADD)
        begin
            if (heap_count >= CAPACITY)
                result_q.push_back(make_result(K_REJECTED, id, 1'b1));
            else
            begin
                pos = heap_count;
                heap_count++;
                heap_deadline[pos] = due;
                heap_owner[pos]    = id;
                heap_dead[pos]     = 1'b0;
                // A parent with an equal deadline stops the climb.
                while (pos > 0 && heap_deadline[(pos - 1) / 2] > due)
                begin
                    swap_slots(pos, (pos - 1) / 2);
                    pos = (pos - 1) / 2;
                end
                result_q.push_back(make_result(K_ADDED, id, 1'b1));
            end
        end
        else if (c == CMD_CANCEL)
        begin
            hit = 1'b0;
            for (int i = 0; i < heap_count; i++)
            begin
                if (heap_owner[i] == id)
                begin
                    heap_dead[i] = 1'b1;
                    hit = 1'b1;
                end
            end
            result_q.push_back(make_result(hit ? K_CANCELLED : K_NOT_FOUND, id, 1'b1));
        end
        else if (c == CMD_TICK)
        begin
            fired = 0;
            while (heap_count > 0 && fired < MAX_FIRED && now >= heap_deadline[0])
            begin
                owner = heap_owner[0];
                live  = !heap_dead[0];
                heap_count--;
                if (heap_count > 0)
                begin
                    heap_deadline[0] = heap_deadline[heap_count];
                    heap_owner[0]    = heap_owner[heap_count];
                    heap_dead[0]     = heap_dead[heap_count];
                    settle_root();
                end
                if (live)
                begin
                    result_q.push_back(make_result(K_FIRED, owner, 1'b0));
                    fired++;
                end
            end
            result_q.push_back(make_result(K_DONE, 8'd0, 1'b1));
        end
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH at %0t: %s got %0d, expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        timer_result_t want;
        if (!rst_n)
        begin
            heap_count      = 0;
            fail_count      = 0;
            checked_results = 0;
            waiting_results = 0;
            result_q.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                checked_results++;
                if (result_q.size() == 0)
                    report_mismatch("unexpected result beat, kind", kind, -1);
                else
                begin
                    want = result_q.pop_front();
                    if (kind !== want.kind)
                        report_mismatch("kind", kind, want.kind);
                    if (fired_id !== want.id)
                        report_mismatch("fired_id", fired_id, want.id);
                    if (entries_used !== want.used)
                        report_mismatch("entries_used", entries_used, want.used);
                    if (last !== want.last)
                        report_mismatch("last", last, want.last);
                end
            end
            if (in_valid && !in_stall)
                predict_timer_op(command, timer_id, expire_time, now_time);
            waiting_results = result_q.size();
        end
    end

endmodule

// File: verif/min_heap_timer_queue_tb.sv
// Testbench top for the min-heap timer queue: clock, reset, command stimulus,
// receiver stalls and the verdict. Depends on mhtq_pkg, the block and the checker.
`timescale 1ns / 100ps

module min_heap_timer_queue_tb;
    import mhtq_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_COMMANDS = 100;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  command = CMD_ADD;
    logic [7:0]  timer_id = '0;
    logic [31:0] expire_time = '0;
    logic [31:0] now_time = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  kind;
    logic [7:0]  fired_id;
    logic [4:0]  entries_used;
    logic        last;

    int fail_count;
    int waiting_results;
    int checked_results;

    // Idle percentages for the sender and the receiver, changed by phase.
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    // A long receiver hold-off is requested by the stimulus and counted out
    // in the receiver process.
    logic hold_request = 1'b0;
    int   hold_left = 0;
    int   cycle_count = 0;
    int   commands_sent = 0;

    always #5 clk = ~clk;

    min_heap_timer_queue i_dut (.*);

    min_heap_timer_queue_chk i_chk (.*);

    // Receiver: stalls at random, or solidly during a requested hold-off.
    always @(negedge clk)
    begin
        if (hold_request)
        begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall = 1'b1;
        end
        else
            out_stall = ($urandom_range(99) < rx_idle_pct);
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Run exceeded %0d cycles with %0d results outstanding",
                     CYCLE_LIMIT, waiting_results);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Offers one command beat. Called at a falling edge and returns at a
    // falling edge after the beat has been taken. The stall seen at the
    // falling edge is what the block presents at the following rising edge.
    task automatic send_command(logic [1:0] c, logic [7:0] id, logic [31:0] due,
                                logic [31:0] now);
        logic stalled;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        command     = c;
        timer_id    = id;
        expire_time = due;
        now_time    = now;
        in_valid    = 1'b1;
        forever
        begin
            stalled = in_stall;
            @(posedge clk);
            @(negedge clk);
            if (!stalled)
                break;
        end
        in_valid = 1'b0;
        if (c != CMD_UNUSED)
            commands_sent++;
    endtask

    task automatic drain_results();
        while (waiting_results != 0)
            @(negedge clk);
    endtask

    initial
    begin
        logic [31:0] clock_now;
        int          pick;
        int          sent;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part. Fill the heap with descending and tied deadlines,
        // including the extreme values, so that adds climb several levels.
        for (int i = 0; i < CAPACITY; i++)
            send_command(CMD_ADD, 8'(i * 17),
                         (i == 3) ? 32'hFFFF_FFFF : (i == 9) ? 32'd0 : 32'(80 - (i / 2) * 10),
                         32'h0);
        // The heap is full, so this add is rejected.
        send_command(CMD_ADD, 8'hAA, 32'd5, 32'hFFFF_FFFF);
        // Cancel the timer with deadline zero, then cancel it again: a match on
        // an already cancelled entry still reports cancelled.
        send_command(CMD_CANCEL, 8'd153, 32'h0, 32'h0);
        send_command(CMD_CANCEL, 8'd153, 32'hFFFF_FFFF, 32'h0);
        send_command(CMD_CANCEL, 8'h5A, 32'h0, 32'h0);
        // The unused command code must be ignored.
        send_command(CMD_UNUSED, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // Time zero pops only the cancelled entry, silently.
        send_command(CMD_TICK, 8'hFF, 32'hFFFF_FFFF, 32'd0);
        send_command(CMD_TICK, 8'h00, 32'h0, 32'd50);
        send_command(CMD_ADD, 8'hFF, 32'd1, 32'h0);
        // The latest possible time empties the heap, then a tick on empty.
        send_command(CMD_TICK, 8'h00, 32'h0, 32'hFFFF_FFFF);
        send_command(CMD_TICK, 8'h00, 32'h0, 32'hFFFF_FFFF);
        drain_results();

        // Random part. Time mostly moves forward in small steps and deadlines
        // sit a little ahead of it, so ticks fire a handful of timers and ids
        // from a small pool make cancels hit. A minority is full range noise.
        clock_now = $urandom_range(1000);
        sent = 0;
        while (sent < RANDOM_COMMANDS)
        begin
            if (sent < RANDOM_COMMANDS / 3)
            begin
                tx_idle_pct = 38;
                rx_idle_pct = 49;
            end
            else if (sent < 2 * RANDOM_COMMANDS / 3)
            begin
                tx_idle_pct = 49;
                rx_idle_pct = 38;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (sent == 45)
                hold_request = 1'b1;
            if (sent == 60)
                drain_results();
            pick = $urandom_range(99);
            if (pick < 45)
                send_command(CMD_ADD,
                             ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(15)),
                             ($urandom_range(9) == 0) ? $urandom
                                                      : clock_now + $urandom_range(60),
                             $urandom);
            else if (pick < 60)
                send_command(CMD_CANCEL,
                             ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(15)),
                             $urandom, $urandom);
            else if (pick < 92)
            begin
                clock_now = clock_now + $urandom_range(40);
                send_command(CMD_TICK, 8'($urandom), $urandom,
                             ($urandom_range(14) == 0) ? $urandom : clock_now);
            end
            else
                send_command(CMD_UNUSED, 8'($urandom), $urandom, $urandom);
            if (command != CMD_UNUSED)
                sent++;
        end

        drain_results();
        repeat (100) @(negedge clk);
        $display("Covered %0d commands: full heap, rejected adds, repeated cancels,",
                 commands_sent);
        $display("ticks at the time extremes and a long output hold-off; %0d results checked.",
                 checked_results);
        if (fail_count == 0 && waiting_results == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: min_heap_timer_queue.f
hw/rtl/mhtq_pkg.sv
hw/rtl/mhtq_datapath.sv
hw/rtl/mhtq_ctrl.sv
hw/rtl/min_heap_timer_queue.sv
verif/min_heap_timer_queue_chk.sv
verif/min_heap_timer_queue_tb.sv
